/* src/fractional_delay_chorus_core_macros.svh */
// assertion macros for the fractional delay chorus core
`ifndef FRACTIONAL_DELAY_CHORUS_CORE_MACROS_SVH
`define FRACTIONAL_DELAY_CHORUS_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FDC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FDC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fdc_pkg.sv */
// shared types, constants and helpers of the fractional delay chorus core
`default_nettype none

package fdc_pkg;

  localparam int AUDIO_W   = 16;
  localparam int DTIME_W   = 22;
  localparam int GAIN_W    = 17;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;

  // 0.001 s and 0.002 s in 2^-30 s units, 0.95 in q0.16
  localparam logic [31:0] CHORUS_BASE = 32'd1073741;
  localparam logic [21:0] CHORUS_SPAN = 22'd2147484;
  localparam logic [15:0] FB_SCALE    = 16'd62259;
  localparam logic [16:0] UNITY       = 17'd65536;

  localparam logic [17:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [15:0] SMOOTH_RST      = 16'd66;
  localparam logic        MODE_RST        = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_RATE = 2'd0,
    REG_SMOOTHING   = 2'd1,
    REG_EFFECT_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMUTH,
    ST_SUM,
    ST_DMUL,
    ST_DCLAMP,
    ST_READ,
    ST_RDAT,
    ST_INTERP,
    ST_MIX,
    ST_OUT
  } state_t;

  function automatic logic signed [AUDIO_W-1:0] sat16(input logic signed [35:0] v);
    logic signed [AUDIO_W-1:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[AUDIO_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/fdc_if.sv */
// valid/ready channel interfaces for samples in and mixed samples out
`default_nettype none

interface fdc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fdc_pkg::AUDIO_W-1:0]    audio_in;
  logic        [fdc_pkg::DTIME_W-1:0]    delay_time;
  logic signed [fdc_pkg::AUDIO_W-1:0]    modulation;
  logic        [fdc_pkg::GAIN_W-1:0]     feedback_amount;
  logic        [fdc_pkg::GAIN_W-1:0]     wet_mix;

  modport source (output valid, output audio_in, output delay_time, output modulation,
                  output feedback_amount, output wet_mix, input ready);
  modport sink   (input valid, input audio_in, input delay_time, input modulation,
                  input feedback_amount, input wet_mix, output ready);
endinterface

interface fdc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [fdc_pkg::AUDIO_W-1:0]    audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink   (input valid, input audio_out, output ready);
endinterface

`default_nettype wire

/* src/fractional_delay_chorus_core.sv */
// fractional delay / chorus core: smoothed delay, interpolated read, feedback, dry/wet mix
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------------
//  in_ch    | in  | valid/ready        | audio_in, delay_time, modulation, feedback, wet
//  out_ch   | out | valid/ready        | audio_out
//  cfg      | in  | cfg_wr_en          | cfg_index, cfg_wdata
//
//  an item walks the sequencer from accept to result through the smoothing, sum, delay
//  multiply, clamp, read, read data, interpolation, mix and output steps, with a registered
//  read of the delay memory; the next sample is taken in the cycle after the result is loaded
//  after reset a clearing pass writes zeros over the memory, and no beat is accepted
//  during it
//  a result waiting in the output register holds the sequencer only in its last step
`default_nettype none
`include "fractional_delay_chorus_core_macros.svh"

module fractional_delay_chorus_core #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fdc_in_if.sink                          in_ch,
  fdc_out_if.source                       out_ch,
  input  logic                            cfg_wr_en,
  input  logic [fdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fdc_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int PW = AW + 16;
  localparam logic [AW-1:0] LAST_IDX = AW'(DELAY_DEPTH - 1);
  localparam logic [PW-1:0] DMAX     = {AW'(DELAY_DEPTH - 1), 16'd0};
  localparam logic [PW:0]   SPAN     = {(AW + 1)'(DELAY_DEPTH), 16'd0};

  // configuration
  logic [17:0] sample_rate_r;
  logic [15:0] smooth_c_r;
  logic        mode_r;

  // control and state
  fdc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_idx_r;
  logic [AW-1:0]   wp_r;
  logic [31:0]     smoothed_r;
  logic signed [15:0] last_r;
  logic            out_valid_r;
  logic signed [15:0] out_audio_r;

  // payload
  logic signed [15:0] audio_r;
  logic [31:0]        target_r;
  logic [16:0]        fb_r;
  logic [16:0]        wet_r;
  logic [48:0]        prod_a_r;
  logic [47:0]        prod_b_r;
  logic [15:0]        g_r;
  logic signed [32:0] fbprod_r;
  logic [49:0]        dprod_r;
  logic signed [15:0] stored_r;
  logic [PW-1:0]      d_r;
  logic [15:0]        t_r;
  logic signed [15:0] rd0_r, rd1_r;
  logic signed [33:0] p0_r, p1_r;
  logic signed [33:0] m0_r, m1_r;

  logic signed [15:0] mem [DELAY_DEPTH];

  // fsm outputs
  logic          in_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic signed [15:0] mem_wdata;
  logic          load_out;

  // combinational datapath
  logic [15:0]        mod_off;
  logic [37:0]        chorus_prod;
  logic [31:0]        target_in;
  logic [16:0]        fb_in_sat, wet_in_sat;
  logic [16:0]        c_inv;
  logic [49:0]        smooth_sum;
  logic signed [32:0] fb_round;
  logic signed [35:0] stored_full;
  logic [35:0]        d_full;
  logic [PW-1:0]      wq;
  logic [PW:0]        rp;
  logic [AW:0]        i1_raw;
  logic [AW-1:0]      i0, i1;
  logic signed [34:0] interp_sum;
  logic signed [35:0] mix_sum;

  always_comb begin
    mod_off     = {~in_ch.modulation[15], in_ch.modulation[14:0]};
    chorus_prod = 38'(fdc_pkg::CHORUS_SPAN) * 38'(mod_off);
    if (mode_r) begin
      target_in = fdc_pkg::CHORUS_BASE + 32'(chorus_prod >> 15);
    end else begin
      target_in = {in_ch.delay_time, 10'd0};
    end
    fb_in_sat  = (in_ch.feedback_amount > fdc_pkg::UNITY) ? fdc_pkg::UNITY
                                                          : in_ch.feedback_amount;
    wet_in_sat = (in_ch.wet_mix > fdc_pkg::UNITY) ? fdc_pkg::UNITY : in_ch.wet_mix;
  end

  always_comb begin
    c_inv       = fdc_pkg::UNITY - {1'b0, smooth_c_r};
    smooth_sum  = 50'(prod_a_r) + 50'(prod_b_r) + 50'd32768;
    fb_round    = (fbprod_r + 33'sd32768) >>> 16;
    stored_full = 36'(audio_r) + 36'(fb_round);
    d_full      = dprod_r[49:14];
    wq          = {wp_r, 16'd0};
    // read position behind the write pointer, wrapped over the store
    if (d_r <= wq) begin
      rp = (PW + 1)'(wq - d_r);
    end else begin
      rp = {1'b0, wq} + SPAN - {1'b0, d_r};
    end
    i1_raw = rp[PW:16];
    i1     = (i1_raw >= (AW + 1)'(DELAY_DEPTH)) ? '0 : i1_raw[AW-1:0];
    i0     = (i1 == '0) ? LAST_IDX : i1 - AW'(1);
    interp_sum = 35'(p0_r) + 35'(p1_r) + 35'sd32768;
    mix_sum    = 36'(m0_r) + 36'(m1_r) + 36'sd32768;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdc_pkg::ST_CLEAR:  if (clr_idx_r == LAST_IDX) state_nxt = fdc_pkg::ST_IDLE;
      fdc_pkg::ST_IDLE:   if (in_ch.valid) state_nxt = fdc_pkg::ST_SMUTH;
      fdc_pkg::ST_SMUTH:  state_nxt = fdc_pkg::ST_SUM;
      fdc_pkg::ST_SUM:    state_nxt = fdc_pkg::ST_DMUL;
      fdc_pkg::ST_DMUL:   state_nxt = fdc_pkg::ST_DCLAMP;
      fdc_pkg::ST_DCLAMP: state_nxt = fdc_pkg::ST_READ;
      fdc_pkg::ST_READ:   state_nxt = fdc_pkg::ST_RDAT;
      fdc_pkg::ST_RDAT:   state_nxt = fdc_pkg::ST_INTERP;
      fdc_pkg::ST_INTERP: state_nxt = fdc_pkg::ST_MIX;
      fdc_pkg::ST_MIX:    state_nxt = fdc_pkg::ST_OUT;
      fdc_pkg::ST_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = fdc_pkg::ST_IDLE;
      default:            state_nxt = fdc_pkg::ST_CLEAR;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = stored_r;
    load_out  = 1'b0;
    case (state_r)
      fdc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      fdc_pkg::ST_IDLE: in_ready = 1'b1;
      // reads were issued in the read step, before this write, so a same-slot read sees the old sample
      fdc_pkg::ST_RDAT: mem_we = 1'b1;
      fdc_pkg::ST_OUT:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.audio_out = out_audio_r;

  // delay memory, two registered read ports and one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd0_r <= mem[i0];
    rd1_r <= mem[i1];
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= fdc_pkg::ST_CLEAR;
      clr_idx_r     <= '0;
      wp_r          <= '0;
      smoothed_r    <= '0;
      last_r        <= '0;
      out_valid_r   <= 1'b0;
      sample_rate_r <= fdc_pkg::SAMPLE_RATE_RST;
      smooth_c_r    <= fdc_pkg::SMOOTH_RST;
      mode_r        <= fdc_pkg::MODE_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == fdc_pkg::ST_CLEAR) begin
        clr_idx_r <= clr_idx_r + AW'(1);
      end
      if (state_r == fdc_pkg::ST_SUM) begin
        smoothed_r <= smooth_sum[47:16];
      end
      if (state_r == fdc_pkg::ST_INTERP) begin
        last_r <= interp_sum[31:16];
        wp_r   <= (wp_r == LAST_IDX) ? '0 : wp_r + AW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          fdc_pkg::REG_SAMPLE_RATE: sample_rate_r <= cfg_wdata;
          fdc_pkg::REG_SMOOTHING:   smooth_c_r    <= cfg_wdata[15:0];
          fdc_pkg::REG_EFFECT_MODE: mode_r        <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      fdc_pkg::ST_IDLE: begin
        audio_r  <= in_ch.audio_in;
        target_r <= target_in;
        fb_r     <= fb_in_sat;
        wet_r    <= wet_in_sat;
      end
      fdc_pkg::ST_SMUTH: begin
        prod_a_r <= 49'(smoothed_r) * 49'(c_inv);
        prod_b_r <= 48'(target_r) * 48'(smooth_c_r);
        g_r      <= 16'((33'(fb_r) * 33'(fdc_pkg::FB_SCALE) + 33'd32768) >> 16);
      end
      fdc_pkg::ST_SUM: begin
        fbprod_r <= 33'(last_r) * 33'($signed({1'b0, g_r}));
      end
      fdc_pkg::ST_DMUL: begin
        dprod_r  <= 50'(smoothed_r) * 50'(sample_rate_r);
        stored_r <= fdc_pkg::sat16(stored_full);
      end
      fdc_pkg::ST_DCLAMP: begin
        d_r <= (d_full > 36'(DMAX)) ? DMAX : PW'(d_full);
      end
      fdc_pkg::ST_READ: begin
        t_r <= rp[15:0];
      end
      fdc_pkg::ST_RDAT: begin
        p0_r <= 34'(rd0_r) * 34'($signed({1'b0, fdc_pkg::UNITY - {1'b0, t_r}}));
        p1_r <= 34'(rd1_r) * 34'($signed({2'b00, t_r}));
      end
      fdc_pkg::ST_MIX: begin
        m0_r <= 34'(audio_r) * 34'($signed({1'b0, fdc_pkg::UNITY - wet_r}));
        m1_r <= 34'(last_r) * 34'($signed({1'b0, wet_r}));
      end
      fdc_pkg::ST_OUT: begin
        if (load_out) begin
          out_audio_r <= fdc_pkg::sat16(mix_sum >>> 16);
        end
      end
      default: ;
    endcase
  end

  `FDC_ASSERT_NXT(a_accept_starts_item, in_ch.valid && in_ch.ready,
                  state_r == fdc_pkg::ST_SMUTH, "accepted beat did not start the sequencer")
  `FDC_ASSERT_IMP(a_result_from_last_step, $rose(out_valid_r),
                  $past(state_r) == fdc_pkg::ST_OUT, "result appeared outside the final step")
  `FDC_ASSERT_NXT(a_wp_moves_once, state_r != fdc_pkg::ST_INTERP, $stable(wp_r),
                  "write pointer moved outside the interpolation step")
  `FDC_ASSERT_IMP(a_delay_clamped, state_r == fdc_pkg::ST_READ, d_r <= DMAX,
                  "delay exceeds the store depth")

endmodule

`default_nettype wire
